### design/mhpq_pkg.sv
// Shared types and constants of the min-heap priority queue.
package mhpq_pkg;

   localparam int PRI_W   = 31;
   localparam int VERT_W  = 11;
   localparam int OP_W    = 3;
   localparam int POS_W   = 10;
   localparam int STS_W   = 2;
   localparam int ENTRY_W = PRI_W + 2 * VERT_W;

   localparam logic [PRI_W-1:0] PRI_INF = '1;
   localparam logic [VERT_W-1:0] VERT_COUNT_RESET = 11'd1024;

   localparam logic [OP_W-1:0] OP_START        = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT       = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE_MIN   = 3'd2;
   localparam logic [OP_W-1:0] OP_DECREASE_KEY = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE_AT    = 3'd4;

   localparam logic [STS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STS_W-1:0] STS_EMPTY   = 2'd1;
   localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
   localparam logic [STS_W-1:0] STS_BAD_POS = 2'd3;

   typedef struct packed {
      logic [PRI_W-1:0]  pri;
      logic [VERT_W-1:0] vert;
      logic [VERT_W-1:0] part;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_SU_CHK,
      S_SU_WAIT,
      S_RM_POS,
      S_RM_LAST,
      S_SD_CHK,
      S_SD_LEFT,
      S_SD_RIGHT,
      S_SCAN,
      S_DONE
   } state_type;

endpackage

### design/mhpq_if.sv
// Request and response channel interfaces of the min-heap priority queue.
interface mhpq_req_if;
   import mhpq_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [VERT_W-1:0] key_a;
   logic [VERT_W-1:0] key_b;
   logic [PRI_W-1:0]  new_priority;
   logic [POS_W-1:0]  position;
   modport source (output valid, opcode, key_a, key_b, new_priority, position, input ready);
   modport sink (input valid, opcode, key_a, key_b, new_priority, position, output ready);
endinterface

interface mhpq_rsp_if;
   import mhpq_pkg::*;
   logic              valid;
   logic              ready;
   logic [STS_W-1:0]  status;
   logic [VERT_W-1:0] out_vertex;
   logic [PRI_W-1:0]  out_priority;
   logic [VERT_W-1:0] out_partner;
   logic [VERT_W-1:0] entries_left;
   modport source (output valid, status, out_vertex, out_priority, out_partner, entries_left,
                   input ready);
   modport sink (input valid, status, out_vertex, out_priority, out_partner, entries_left,
                 output ready);
endinterface

### design/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
   parameter int WIDTH = 53,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### design/min_heap_priority_queue.sv
// Top level of the min-heap priority queue built around one entry RAM; one operation at a time.
// Start fills n entries (n the vertex count clamped to MAX_ENTRIES); insert sifts the new entry
// up; delete reads the removed entry and the last entry, then sifts down.
// Decrease-key scans the entries in order and sifts each lowered entry up.
// The next request is taken in the cycle after the response beat is loaded, so a new operation
// is not accepted before the last one is through. Reset clears the count, response valid and sets
// vertex_count to 1024; the RAM is not cleared, as only entries below the count are read.
module min_heap_priority_queue #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   mhpq_req_if.sink                   req_bus,
   mhpq_rsp_if.source                 rsp_bus,
   input  logic                       csr_we,
   input  logic [mhpq_pkg::VERT_W-1:0] csr_wdata
);
   import mhpq_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int XW = AW + 2;

   typedef logic [XW-1:0] ext_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [VERT_W-1:0] vc_ff, vc_in;
   logic [AW-1:0]     i_ff, i_in;
   entry_type         e_ff, e_in;
   entry_type         lch_ff, lch_in;
   entry_type         out_ff, out_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic [AW-1:0]     chk_ff, chk_in;
   logic              pend_ff, pend_in;
   logic              ret_scan_ff, ret_scan_in;
   logic [VERT_W-1:0] ka_ff, ka_in;
   logic [VERT_W-1:0] kb_ff, kb_in;
   logic [PRI_W-1:0]  np_ff, np_in;
   logic [STS_W-1:0]  st_ff, st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0]  rsp_status_ff, rsp_status_in;
   entry_type         rsp_ent_ff, rsp_ent_in;
   logic [VERT_W-1:0] rsp_left_ff, rsp_left_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   entry_type         ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type         rd_ent;

   logic              req_fire, is_empty, is_full, bad_pos;
   logic [CW-1:0]     load_n;
   ext_type           cnt_x, left_x, right_x;
   logic [AW-1:0]     parent_idx;
   logic              match_a, match_b, scan_more, su_up;
   logic              l_in_heap, r_in_heap, left_sm, lch_sm, right_sm;
   logic [PRI_W-1:0]  best_pri;

   mhpq_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_ent     = entry_type'(ram_rdata);
   assign req_fire   = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign is_empty   = (count_ff == '0);
   assign is_full    = (32'(count_ff) >= 32'(MAX_ENTRIES));
   assign bad_pos    = (32'(req_bus.position) >= 32'(count_ff));
   assign load_n     = (32'(vc_ff) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(vc_ff);
   assign cnt_x      = ext_type'(count_ff);
   assign left_x     = {1'b0, i_ff, 1'b1};
   assign right_x    = left_x + ext_type'(1);
   assign parent_idx = (i_ff - AW'(1)) >> 1;
   assign scan_more  = (scan_ff < count_ff);
   assign match_a    = pend_ff && (rd_ent.vert == ka_ff) && (rd_ent.pri > np_ff);
   assign match_b    = pend_ff && (rd_ent.vert != ka_ff) && (rd_ent.vert == kb_ff)
                       && (rd_ent.pri > np_ff);
   assign su_up      = (rd_ent.pri > e_ff.pri);
   assign l_in_heap  = (left_x < cnt_x);
   assign r_in_heap  = (right_x < cnt_x);
   assign left_sm    = (rd_ent.pri < e_ff.pri);
   assign lch_sm     = (lch_ff.pri < e_ff.pri);
   assign best_pri   = lch_sm ? lch_ff.pri : e_ff.pri;
   assign right_sm   = (rd_ent.pri < best_pri);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_bus.opcode)
                  OP_START:        state_in = S_FILL;
                  OP_INSERT:       state_in = is_full ? S_DONE : S_SU_CHK;
                  OP_DELETE_MIN:   state_in = is_empty ? S_DONE : S_RM_POS;
                  OP_DELETE_AT:    state_in = (is_empty || bad_pos) ? S_DONE : S_RM_POS;
                  OP_DECREASE_KEY: state_in = S_SCAN;
                  default:         state_in = S_DONE;
               endcase
            end
         end
         S_FILL: begin
            if (fill_ff >= load_n) begin
               state_in = S_DONE;
            end
         end
         S_SU_CHK: begin
            if (i_ff == '0) begin
               state_in = ret_scan_ff ? S_SCAN : S_DONE;
            end else begin
               state_in = S_SU_WAIT;
            end
         end
         S_SU_WAIT: begin
            if (su_up) begin
               state_in = S_SU_CHK;
            end else begin
               state_in = ret_scan_ff ? S_SCAN : S_DONE;
            end
         end
         S_RM_POS:  state_in = S_RM_LAST;
         S_RM_LAST: state_in = S_SD_CHK;
         S_SD_CHK:  state_in = l_in_heap ? S_SD_LEFT : S_DONE;
         S_SD_LEFT: begin
            if (r_in_heap) begin
               state_in = S_SD_RIGHT;
            end else begin
               state_in = left_sm ? S_SD_CHK : S_DONE;
            end
         end
         S_SD_RIGHT: state_in = (right_sm || lch_sm) ? S_SD_CHK : S_DONE;
         S_SCAN: begin
            if (match_a || match_b) begin
               state_in = S_SU_CHK;
            end else if (!scan_more) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      vc_in         = csr_we ? csr_wdata : vc_ff;
      i_in          = i_ff;
      e_in          = e_ff;
      lch_in        = lch_ff;
      out_in        = out_ff;
      fill_in       = fill_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      pend_in       = pend_ff;
      ret_scan_in   = ret_scan_ff;
      ka_in         = ka_ff;
      kb_in         = kb_ff;
      np_in         = np_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_ent_in    = rsp_ent_ff;
      rsp_left_in   = rsp_left_ff;
      ram_we        = 1'b0;
      ram_waddr     = i_ff;
      ram_wdata     = e_ff;
      ram_re        = 1'b0;
      ram_raddr     = i_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ka_in  = req_bus.key_a;
               kb_in  = req_bus.key_b;
               np_in  = req_bus.new_priority;
               st_in  = STS_OK;
               out_in = '0;
               case (req_bus.opcode)
                  OP_START: fill_in = '0;
                  OP_INSERT: begin
                     if (is_full) begin
                        st_in = STS_FULL;
                     end else begin
                        e_in        = '{pri: req_bus.new_priority, vert: req_bus.key_a,
                                        part: req_bus.key_b};
                        i_in        = AW'(count_ff);
                        count_in    = count_ff + CW'(1);
                        ret_scan_in = 1'b0;
                     end
                  end
                  OP_DELETE_MIN: begin
                     if (is_empty) begin
                        st_in = STS_EMPTY;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        i_in      = '0;
                     end
                  end
                  OP_DELETE_AT: begin
                     if (is_empty) begin
                        st_in = STS_EMPTY;
                     end else if (bad_pos) begin
                        st_in = STS_BAD_POS;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(req_bus.position);
                        i_in      = AW'(req_bus.position);
                     end
                  end
                  OP_DECREASE_KEY: begin
                     scan_in = '0;
                     pend_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_FILL: begin
            if (fill_ff < load_n) begin
               ram_we    = 1'b1;
               ram_waddr = AW'(fill_ff);
               ram_wdata = '{pri: PRI_INF, vert: VERT_W'(32'(fill_ff) + 32'd1), part: '0};
               fill_in   = fill_ff + CW'(1);
            end else begin
               count_in = load_n;
            end
         end
         S_SU_CHK: begin
            if (i_ff == '0) begin
               ram_we  = 1'b1;
               scan_in = CW'(chk_ff) + CW'(1);
               pend_in = 1'b0;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = parent_idx;
            end
         end
         S_SU_WAIT: begin
            ram_we = 1'b1;
            if (su_up) begin
               ram_wdata = rd_ent;
               i_in      = parent_idx;
            end else begin
               scan_in = CW'(chk_ff) + CW'(1);
               pend_in = 1'b0;
            end
         end
         S_RM_POS: begin
            out_in    = rd_ent;
            ram_re    = 1'b1;
            ram_raddr = AW'(count_ff - CW'(1));
            count_in  = count_ff - CW'(1);
         end
         S_RM_LAST: e_in = rd_ent;
         S_SD_CHK: begin
            if (l_in_heap) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(left_x);
            end else begin
               ram_we = 1'b1;
            end
         end
         S_SD_LEFT: begin
            lch_in = rd_ent;
            if (r_in_heap) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(right_x);
            end else begin
               ram_we = 1'b1;
               if (left_sm) begin
                  ram_wdata = rd_ent;
                  i_in      = AW'(left_x);
               end
            end
         end
         S_SD_RIGHT: begin
            ram_we = 1'b1;
            if (right_sm) begin
               ram_wdata = rd_ent;
               i_in      = AW'(right_x);
            end else if (lch_sm) begin
               ram_wdata = lch_ff;
               i_in      = AW'(left_x);
            end
         end
         S_SCAN: begin
            if (match_a || match_b) begin
               e_in        = '{pri: np_ff, vert: rd_ent.vert, part: match_a ? kb_ff : ka_ff};
               i_in        = chk_ff;
               ret_scan_in = match_b;
               pend_in     = 1'b0;
            end else if (scan_more) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(scan_ff);
               chk_in    = AW'(scan_ff);
               pend_in   = 1'b1;
               scan_in   = scan_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_ent_in    = out_ff;
               rsp_left_in   = VERT_W'(count_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         vc_ff        <= VERT_COUNT_RESET;
         pend_ff      <= 1'b0;
         ret_scan_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         vc_ff        <= vc_in;
         pend_ff      <= pend_in;
         ret_scan_ff  <= ret_scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      e_ff          <= e_in;
      lch_ff        <= lch_in;
      out_ff        <= out_in;
      fill_ff       <= fill_in;
      scan_ff       <= scan_in;
      chk_ff        <= chk_in;
      ka_ff         <= ka_in;
      kb_ff         <= kb_in;
      np_ff         <= np_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_left_ff   <= rsp_left_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.out_vertex   = rsp_ent_ff.vert;
   assign rsp_bus.out_priority = rsp_ent_ff.pri;
   assign rsp_bus.out_partner  = rsp_ent_ff.part;
   assign rsp_bus.entries_left = rsp_left_ff;
endmodule

### design/mhpq_checker.sv
// Port-level checks on the response channel of the min-heap priority queue.
module mhpq_checker #(
   parameter int MAX_ENTRIES = 1024
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mhpq_pkg::STS_W-1:0]  status,
   input logic [mhpq_pkg::VERT_W-1:0] out_vertex,
   input logic [mhpq_pkg::PRI_W-1:0]  out_priority,
   input logic [mhpq_pkg::VERT_W-1:0] out_partner,
   input logic [mhpq_pkg::VERT_W-1:0] entries_left
);
   import mhpq_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entries_left))
      else $error("Stalled response beat changed.");

   a_no_entry_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != STS_OK |-> out_vertex == '0 && out_priority == '0
         && out_partner == '0)
      else $error("Failed operation reported a removed entry.");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STS_EMPTY |-> entries_left == '0)
      else $error("Empty status with entries left.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STS_FULL |-> entries_left == VERT_W'(MAX_ENTRIES))
      else $error("Full status with a count below capacity.");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");
endmodule

bind min_heap_priority_queue mhpq_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_mhpq_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .status       (rsp_bus.status),
   .out_vertex   (rsp_bus.out_vertex),
   .out_priority (rsp_bus.out_priority),
   .out_partner  (rsp_bus.out_partner),
   .entries_left (rsp_bus.entries_left)
);

### tb/min_heap_priority_queue_test.sv
// Self-checking testbench of the min-heap priority queue: directed and random operations.
module min_heap_priority_queue_test;
   import mhpq_pkg::*;

   localparam int HEAP_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST = 3'd7;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic [VERT_W-1:0] vertex;
      logic [PRI_W-1:0]  pri;
      logic [VERT_W-1:0] partner;
      logic [VERT_W-1:0] left;
   } rsp_beat_type;

   class heap_scoreboard;
      entry_type heap[HEAP_DEPTH];
      int unsigned count;
      logic [VERT_W-1:0] vertex_count;
      rsp_beat_type pending[$];
      int mismatches;

      function new();
         count = 0;
         vertex_count = VERT_COUNT_RESET;
         mismatches = 0;
      endfunction

      function void swap_entries(int unsigned a, int unsigned b);
         entry_type t;
         t = heap[a];
         heap[a] = heap[b];
         heap[b] = t;
      endfunction

      function void climb(int unsigned i);
         int unsigned p;
         while (i != 0) begin
            p = (i - 1) / 2;
            if (heap[p].pri <= heap[i].pri) break;
            swap_entries(i, p);
            i = p;
         end
      endfunction

      function void descend(int unsigned i);
         int unsigned l, r, s;
         while (i < count) begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            s = i;
            if (l < count && heap[l].pri < heap[s].pri) s = l;
            if (r < count && heap[r].pri < heap[s].pri) s = r;
            if (s == i) break;
            swap_entries(i, s);
            i = s;
         end
      endfunction

      function void take_out(int unsigned i, inout rsp_beat_type r);
         r.vertex = heap[i].vert;
         r.pri = heap[i].pri;
         r.partner = heap[i].part;
         heap[i] = heap[count-1];
         count = count - 1;
         descend(i);
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [VERT_W-1:0] ka,
                                 logic [VERT_W-1:0] kb, logic [PRI_W-1:0] np,
                                 logic [POS_W-1:0] pos);
         rsp_beat_type r;
         int unsigned n;
         r = '0;
         r.status = STS_OK;
         case (op)
            OP_START: begin
               n = (vertex_count > HEAP_DEPTH) ? HEAP_DEPTH : vertex_count;
               for (int unsigned i = 0; i < n; i++) begin
                  heap[i].pri = PRI_INF;
                  heap[i].vert = VERT_W'(i + 1);
                  heap[i].part = '0;
               end
               count = n;
            end
            OP_INSERT: begin
               if (count >= HEAP_DEPTH) begin
                  r.status = STS_FULL;
               end else begin
                  heap[count].pri = np;
                  heap[count].vert = ka;
                  heap[count].part = kb;
                  count = count + 1;
                  climb(count - 1);
               end
            end
            OP_DELETE_MIN: begin
               if (count == 0) r.status = STS_EMPTY;
               else take_out(0, r);
            end
            OP_DECREASE_KEY: begin
               for (int unsigned i = 0; i < count; i++) begin
                  if (heap[i].vert == ka) begin
                     if (heap[i].pri > np) begin
                        heap[i].pri = np;
                        heap[i].part = kb;
                        climb(i);
                        break;
                     end
                  end else if (heap[i].vert == kb) begin
                     if (heap[i].pri > np) begin
                        heap[i].pri = np;
                        heap[i].part = ka;
                        climb(i);
                     end
                  end
               end
            end
            OP_DELETE_AT: begin
               if (count == 0) r.status = STS_EMPTY;
               else if (pos >= count) r.status = STS_BAD_POS;
               else take_out(pos, r);
            end
            default: ;
         endcase
         r.left = VERT_W'(count);
         pending.push_back(r);
      endfunction

      function void check_response(rsp_beat_type got);
         rsp_beat_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response beat: %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Response mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [VERT_W-1:0] csr_wdata = '0;
   bit no_idling = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int unsigned cycles = 0;
   heap_scoreboard sb = new();

   mhpq_req_if req();
   mhpq_rsp_if rsp();

   min_heap_priority_queue dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req),
      .rsp_bus(rsp),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.opcode = OP_START;
      req.key_a = '0;
      req.key_b = '0;
      req.new_priority = '0;
      req.position = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("min_heap_priority_queue_test NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= no_idling || ($urandom_range(0, 99) >= 14);
      end
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         sb.note_request(req.opcode, req.key_a, req.key_b, req.new_priority, req.position);
      if (!reset && rsp.valid && rsp.ready)
         sb.check_response({rsp.status, rsp.out_vertex, rsp.out_priority, rsp.out_partner,
                            rsp.entries_left});
   end

   task automatic send(logic [OP_W-1:0] op, logic [VERT_W-1:0] ka, logic [VERT_W-1:0] kb,
                       logic [PRI_W-1:0] np, logic [POS_W-1:0] pos);
      req.valid <= 1'b1;
      req.opcode <= op;
      req.key_a <= ka;
      req.key_b <= kb;
      req.new_priority <= np;
      req.position <= pos;
      do @(posedge clock); while (!req.ready);
      if (!no_idling && $urandom_range(0, 99) < 14) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_vertex_count(logic [VERT_W-1:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      sb.vertex_count = value;
      csr_we <= 1'b0;
   endtask

   function automatic logic [OP_W-1:0] spare_opcode();
      return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
   endfunction

   task automatic random_item();
      int pick;
      logic [OP_W-1:0] op;
      logic [VERT_W-1:0] ka, kb;
      logic [PRI_W-1:0] np;
      logic [POS_W-1:0] pos;
      pick = $urandom_range(0, 99);
      if (pick < 28) op = OP_INSERT;
      else if (pick < 52) op = OP_DELETE_MIN;
      else if (pick < 76) op = OP_DECREASE_KEY;
      else if (pick < 92) op = OP_DELETE_AT;
      else if (pick < 96) op = OP_START;
      else op = spare_opcode();
      if ($urandom_range(0, 9) < 8) begin
         ka = VERT_W'($urandom_range(0, sb.vertex_count + 3));
         kb = VERT_W'($urandom_range(0, sb.vertex_count + 3));
      end else begin
         ka = VERT_W'($urandom_range(0, 1024));
         kb = VERT_W'($urandom_range(0, 1024));
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) np = PRI_W'($urandom_range(0, 15));
      else if (pick < 8) np = PRI_W'({$urandom} >> 1);
      else if (pick < 9) np = PRI_INF;
      else np = PRI_INF - 1;
      if ($urandom_range(0, 9) < 8) pos = POS_W'($urandom_range(0, sb.count + 1));
      else pos = POS_W'($urandom);
      send(op, ka, kb, np, pos);
   endtask

   task automatic random_phase(logic [VERT_W-1:0] vcount, int items, bit quiet);
      set_vertex_count(vcount);
      no_idling = quiet;
      send(OP_START, '0, '0, '0, '0);
      for (int i = 0; i < items; i++) begin
         if (i == items / 2 && vcount == 9) hold_request = 1'b1;
         if (i == items / 3 && vcount == 31) drain();
         random_item();
      end
      no_idling = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full heap at the reset vertex count.
      send(OP_START, '0, '0, '0, '0);
      send(OP_INSERT, 11'd5, 11'd6, 31'd1, '0);
      send(OP_DECREASE_KEY, 11'd1024, 11'd1, 31'd0, '0);
      send(OP_DECREASE_KEY, 11'd3, 11'd3, 31'd7, '0);
      send(OP_DELETE_AT, '0, '0, '0, 10'd1023);
      send(OP_DELETE_AT, '0, '0, '0, 10'd1023);
      send(OP_DELETE_MIN, '0, '0, '0, '0);
      send(OP_DELETE_MIN, '0, '0, '0, '0);
      send(OP_SPARE_FIRST, 11'd1024, 11'd1024, PRI_INF, 10'd1023);
      send(OP_SPARE_LAST, '0, '0, '0, '0);

      // Empty heap cases.
      set_vertex_count(11'd0);
      send(OP_START, '0, '0, '0, '0);
      send(OP_DELETE_MIN, '0, '0, '0, '0);
      send(OP_DELETE_AT, '0, '0, '0, '0);
      send(OP_DECREASE_KEY, 11'd1, 11'd2, 31'd0, '0);
      send(OP_INSERT, 11'd0, 11'd1024, PRI_INF, '0);
      send(OP_INSERT, 11'd1024, 11'd0, 31'd0, '0);
      send(OP_INSERT, 11'd7, 11'd7, 31'd0, '0);
      send(OP_DELETE_AT, '0, '0, '0, 10'd3);
      send(OP_DECREASE_KEY, 11'd0, 11'd1024, 31'd0, '0);
      send(OP_DELETE_AT, '0, '0, '0, 10'd1);
      send(OP_DELETE_MIN, '0, '0, '0, '0);
      send(OP_DELETE_MIN, '0, '0, '0, '0);

      // Random phases at several vertex counts; an oversized count clamps to the heap depth.
      random_phase(11'd2047, 12, 1'b0);
      random_phase(11'd1, 30, 1'b0);
      random_phase(11'd9, 110, 1'b0);
      random_phase(11'd31, 110, 1'b1);
      random_phase(11'd16, 100, 1'b0);
      random_phase(11'd5, 90, 1'b0);
      random_phase(11'd64, 90, 1'b0);

      drain();
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("min_heap_priority_queue_test OK");
      else
         $display("min_heap_priority_queue_test NOT OK");
      $finish;
   end

endmodule

### files.f
design/mhpq_pkg.sv
design/mhpq_if.sv
design/mhpq_ram.sv
design/min_heap_priority_queue.sv
design/mhpq_checker.sv
tb/min_heap_priority_queue_test.sv
